### rtl/core/circular_aperture_pixel_coverage_unit_assert.svh
// ----------------------------------------------------------------------------
// circular aperture pixel coverage assertion macros
// shared concurrent assertion forms for the coverage unit rtl
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_APERTURE_PIXEL_COVERAGE_UNIT_ASSERT_SVH
`define CIRCULAR_APERTURE_PIXEL_COVERAGE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define CAP_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// same-cycle implication
`define CAP_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg
// widths, codes and shared types of the aperture coverage pipeline
// ----------------------------------------------------------------------------
package cap_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_SIDE   = 1024;

    localparam int IDX_W      = 11;
    localparam int INV_W      = 17;
    localparam int RAD_W      = 19;
    localparam int CFG_DATA_W = RAD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int COV_W      = FRAC_BITS + 1;

    localparam int S_TDATA_W  = ((2 * IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((COV_W + 7) / 8) * 8;

    localparam int HALF_W     = INV_W - 1;
    localparam int PROD_W     = IDX_W + INV_W;
    localparam int COORD_W    = FRAC_BITS + 4;
    localparam int LO_W       = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int ARG_W      = 2 * FRAC_BITS + 1;
    localparam int ROOT_W     = FRAC_BITS + 1;
    localparam int SQRT_STEPS = (ARG_W + 1) / 2;
    localparam int SQRT_RES_W = ARG_W + 1;
    localparam int SPAN_W     = INV_W;
    localparam int NUM_W      = 2 * SPAN_W;
    localparam int REM_W      = NUM_W + 1;
    localparam int DIV_STAGES = FRAC_BITS + 1;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [SUM_W-1:0]   UNIT_SQ   = SUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [COV_W-1:0]   UNIT_COV  = COV_W'(1) << FRAC_BITS;

    localparam logic [IDX_W-1:0]   SIDE_RST  = IDX_W'(256);
    localparam logic [INV_W-1:0]   INV_RST   = INV_W'(512);

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_RADIUS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_PIXELS  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FULL = 2'd1,
        CLS_PART = 2'd2
    } cap_cls_t;

    typedef struct packed {
        logic [IDX_W-1:0]  center;
        logic [INV_W-1:0]  inv;
        logic [HALF_W-1:0] half;
    } cap_cfg_t;

    typedef struct packed {
        cap_cls_t           cls;
        logic [SPAN_W-1:0]  span;
        logic [LO_W-1:0]    lo_sel;
        logic [COORD_W-1:0] hi_sel;
    } cap_part_t;

endpackage

### rtl/core/cap_front.sv
// ----------------------------------------------------------------------------
// cap_front
// pixel bounds: center offsets, scaling, margins, squared radii, classification
// ----------------------------------------------------------------------------
module cap_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  cap_pkg::cap_cfg_t                 cfg,
    input  logic                              in_valid,
    input  logic [cap_pkg::IDX_W-1:0]         in_col,
    input  logic [cap_pkg::IDX_W-1:0]         in_row,
    output logic                              out_valid,
    output logic [cap_pkg::ARG_W-1:0]         out_arg,
    output cap_pkg::cap_part_t                out_part
);

    function automatic logic [cap_pkg::COORD_W-1:0] sat_hi(
        input logic [cap_pkg::PROD_W-1:0] c,
        input logic [cap_pkg::HALF_W-1:0] h
    );
        logic [cap_pkg::PROD_W:0] s;
        s = {1'b0, c} + (cap_pkg::PROD_W + 1)'(h);
        return (s > (cap_pkg::PROD_W + 1)'(cap_pkg::COORD_MAX)) ?
            cap_pkg::COORD_MAX : s[cap_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [cap_pkg::LO_W-1:0] sat_lo(
        input logic [cap_pkg::PROD_W-1:0] c,
        input logic [cap_pkg::HALF_W-1:0] h
    );
        logic signed [cap_pkg::PROD_W+1:0] s;
        s = $signed({2'b00, c}) - $signed((cap_pkg::PROD_W + 2)'(h));
        return (s > $signed((cap_pkg::PROD_W + 2)'(cap_pkg::COORD_MAX))) ?
            cap_pkg::LO_W'(cap_pkg::COORD_MAX) : s[cap_pkg::LO_W-1:0];
    endfunction

    function automatic logic [cap_pkg::COORD_W-1:0] mag(input logic [cap_pkg::LO_W-1:0] v);
        logic [cap_pkg::LO_W-1:0] n;
        n = -v;
        return v[cap_pkg::LO_W-1] ? n[cap_pkg::COORD_W-1:0] : v[cap_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [cap_pkg::SPAN_W-1:0] span_of(
        input logic [cap_pkg::COORD_W-1:0] hi,
        input logic [cap_pkg::LO_W-1:0]    lo
    );
        logic signed [cap_pkg::LO_W:0] t;
        t = $signed({2'b00, hi}) - $signed({lo[cap_pkg::LO_W-1], lo});
        return t[cap_pkg::SPAN_W-1:0];
    endfunction

    // stage 1: offsets from center
    logic                          s1_v_reg,  s1_v_next;
    logic [cap_pkg::IDX_W-1:0]     s1_dx_reg, s1_dx_next;
    logic [cap_pkg::IDX_W-1:0]     s1_dy_reg, s1_dy_next;
    // stage 2: scaled offsets
    logic                          s2_v_reg,  s2_v_next;
    logic [cap_pkg::PROD_W-1:0]    s2_cx_reg, s2_cx_next;
    logic [cap_pkg::PROD_W-1:0]    s2_cy_reg, s2_cy_next;
    // stage 3: pixel bounds
    logic                          s3_v_reg,  s3_v_next;
    logic [cap_pkg::LO_W-1:0]      s3_xl_reg, s3_xl_next;
    logic [cap_pkg::LO_W-1:0]      s3_yl_reg, s3_yl_next;
    logic [cap_pkg::COORD_W-1:0]   s3_xh_reg, s3_xh_next;
    logic [cap_pkg::COORD_W-1:0]   s3_yh_reg, s3_yh_next;
    // stage 4: squares
    logic                          s4_v_reg,   s4_v_next;
    logic [cap_pkg::LO_W-1:0]      s4_xl_reg,  s4_xl_next;
    logic [cap_pkg::LO_W-1:0]      s4_yl_reg,  s4_yl_next;
    logic [cap_pkg::COORD_W-1:0]   s4_xh_reg,  s4_xh_next;
    logic [cap_pkg::COORD_W-1:0]   s4_yh_reg,  s4_yh_next;
    logic [cap_pkg::SQ_W-1:0]      s4_xls_reg, s4_xls_next;
    logic [cap_pkg::SQ_W-1:0]      s4_yls_reg, s4_yls_next;
    logic [cap_pkg::SQ_W-1:0]      s4_xhs_reg, s4_xhs_next;
    logic [cap_pkg::SQ_W-1:0]      s4_yhs_reg, s4_yhs_next;
    // stage 5: classification and root argument
    logic                          s5_v_reg,    s5_v_next;
    logic [cap_pkg::ARG_W-1:0]     s5_arg_reg,  s5_arg_next;
    cap_pkg::cap_part_t            s5_part_reg, s5_part_next;

    logic [cap_pkg::COORD_W-1:0]   xl_mag, yl_mag;
    logic [cap_pkg::SUM_W-1:0]     rsl, rsh, sel_sq, arg_full;
    logic                          x_dom;

    always_comb begin
        s1_v_next  = in_valid;
        s1_dx_next = (in_col >= cfg.center) ? in_col - cfg.center : cfg.center - in_col;
        s1_dy_next = (in_row >= cfg.center) ? in_row - cfg.center : cfg.center - in_row;

        s2_v_next  = s1_v_reg;
        s2_cx_next = cap_pkg::PROD_W'(s1_dx_reg) * cap_pkg::PROD_W'(cfg.inv);
        s2_cy_next = cap_pkg::PROD_W'(s1_dy_reg) * cap_pkg::PROD_W'(cfg.inv);

        s3_v_next  = s2_v_reg;
        s3_xl_next = sat_lo(s2_cx_reg, cfg.half);
        s3_yl_next = sat_lo(s2_cy_reg, cfg.half);
        s3_xh_next = sat_hi(s2_cx_reg, cfg.half);
        s3_yh_next = sat_hi(s2_cy_reg, cfg.half);

        xl_mag      = mag(s3_xl_reg);
        yl_mag      = mag(s3_yl_reg);
        s4_v_next   = s3_v_reg;
        s4_xl_next  = s3_xl_reg;
        s4_yl_next  = s3_yl_reg;
        s4_xh_next  = s3_xh_reg;
        s4_yh_next  = s3_yh_reg;
        s4_xls_next = cap_pkg::SQ_W'(xl_mag) * cap_pkg::SQ_W'(xl_mag);
        s4_yls_next = cap_pkg::SQ_W'(yl_mag) * cap_pkg::SQ_W'(yl_mag);
        s4_xhs_next = cap_pkg::SQ_W'(s3_xh_reg) * cap_pkg::SQ_W'(s3_xh_reg);
        s4_yhs_next = cap_pkg::SQ_W'(s3_yh_reg) * cap_pkg::SQ_W'(s3_yh_reg);

        rsl      = cap_pkg::SUM_W'(s4_xls_reg) + cap_pkg::SUM_W'(s4_yls_reg);
        rsh      = cap_pkg::SUM_W'(s4_xhs_reg) + cap_pkg::SUM_W'(s4_yhs_reg);
        x_dom    = s4_xh_reg > s4_yh_reg;
        sel_sq   = cap_pkg::SUM_W'(x_dom ? s4_yhs_reg : s4_xhs_reg);
        arg_full = cap_pkg::UNIT_SQ - sel_sq;

        s5_v_next   = s4_v_reg;
        s5_arg_next = (sel_sq < cap_pkg::UNIT_SQ) ? arg_full[cap_pkg::ARG_W-1:0] : '0;
        if (rsl > cap_pkg::UNIT_SQ) begin
            s5_part_next.cls = cap_pkg::CLS_ZERO;
        end else if (rsh < cap_pkg::UNIT_SQ) begin
            s5_part_next.cls = cap_pkg::CLS_FULL;
        end else if (cfg.half == '0) begin
            s5_part_next.cls = cap_pkg::CLS_ZERO;
        end else begin
            s5_part_next.cls = cap_pkg::CLS_PART;
        end
        s5_part_next.span   = x_dom ? span_of(s4_yh_reg, s4_yl_reg) : span_of(s4_xh_reg, s4_xl_reg);
        s5_part_next.lo_sel = x_dom ? s4_xl_reg : s4_yl_reg;
        s5_part_next.hi_sel = x_dom ? s4_xh_reg : s4_yh_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            s4_v_reg <= s4_v_next;
            s5_v_reg <= s5_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s2_cx_reg   <= s2_cx_next;
            s2_cy_reg   <= s2_cy_next;
            s3_xl_reg   <= s3_xl_next;
            s3_yl_reg   <= s3_yl_next;
            s3_xh_reg   <= s3_xh_next;
            s3_yh_reg   <= s3_yh_next;
            s4_xl_reg   <= s4_xl_next;
            s4_yl_reg   <= s4_yl_next;
            s4_xh_reg   <= s4_xh_next;
            s4_yh_reg   <= s4_yh_next;
            s4_xls_reg  <= s4_xls_next;
            s4_yls_reg  <= s4_yls_next;
            s4_xhs_reg  <= s4_xhs_next;
            s4_yhs_reg  <= s4_yhs_next;
            s5_arg_reg  <= s5_arg_next;
            s5_part_reg <= s5_part_next;
        end
    end

    assign out_valid = s5_v_reg;
    assign out_arg   = s5_arg_reg;
    assign out_part  = s5_part_reg;

endmodule

### rtl/core/cap_isqrt.sv
// ----------------------------------------------------------------------------
// cap_isqrt
// pipelined integer square root, one root bit per stage, side data carried along
// ----------------------------------------------------------------------------
module cap_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cap_pkg::ARG_W-1:0]     in_arg,
    input  cap_pkg::cap_part_t            in_part,
    output logic                          out_valid,
    output logic [cap_pkg::ROOT_W-1:0]    out_root,
    output cap_pkg::cap_part_t            out_part
);

    localparam int N = cap_pkg::SQRT_STEPS;
    localparam int RW = cap_pkg::SQRT_RES_W;

    logic                       v_reg    [N];
    logic                       v_next   [N];
    logic [RW-1:0]              rem_reg  [N];
    logic [RW-1:0]              rem_next [N];
    logic [RW-1:0]              res_reg  [N];
    logic [RW-1:0]              res_next [N];
    cap_pkg::cap_part_t         part_reg [N];
    cap_pkg::cap_part_t         part_next[N];

    logic                       v_src    [N];
    logic [RW-1:0]              rem_src  [N];
    logic [RW-1:0]              res_src  [N];
    cap_pkg::cap_part_t         part_src [N];
    logic [RW-1:0]              trial    [N];

    always_comb begin
        v_src[0]    = in_valid;
        rem_src[0]  = RW'(in_arg);
        res_src[0]  = '0;
        part_src[0] = in_part;
        for (int k = 1; k < N; k++) begin
            v_src[k]    = v_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            res_src[k]  = res_reg[k-1];
            part_src[k] = part_reg[k-1];
        end
        for (int k = 0; k < N; k++) begin
            trial[k]     = res_src[k] + (RW'(1) << (2 * (N - 1 - k)));
            v_next[k]    = v_src[k];
            part_next[k] = part_src[k];
            if (rem_src[k] >= trial[k]) begin
                rem_next[k] = rem_src[k] - trial[k];
                res_next[k] = (res_src[k] >> 1) + (RW'(1) << (2 * (N - 1 - k)));
            end else begin
                rem_next[k] = rem_src[k];
                res_next[k] = res_src[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < N; k++) begin
                v_reg[k] <= v_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rem_reg[k]  <= rem_next[k];
                res_reg[k]  <= res_next[k];
                part_reg[k] <= part_next[k];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = res_reg[N-1][cap_pkg::ROOT_W-1:0];
    assign out_part  = part_reg[N-1];

endmodule

### rtl/core/cap_ratio.sv
// ----------------------------------------------------------------------------
// cap_ratio
// edge estimate: clipped chord, area product, pipelined restoring divide
// ----------------------------------------------------------------------------
module cap_ratio (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [cap_pkg::NUM_W-1:0]     den,
    input  logic                          in_valid,
    input  logic [cap_pkg::ROOT_W-1:0]    in_root,
    input  cap_pkg::cap_part_t            in_part,
    output logic                          out_valid,
    output logic [cap_pkg::COV_W-1:0]     out_cov
);

    localparam int F  = cap_pkg::FRAC_BITS;
    localparam int DS = cap_pkg::DIV_STAGES;
    localparam int SW = cap_pkg::LO_W + 1;

    // chord stage
    logic                          b_v_reg,   b_v_next;
    cap_pkg::cap_cls_t             b_cls_reg, b_cls_next;
    logic [cap_pkg::SPAN_W-1:0]    b_a_reg,   b_a_next;
    logic [cap_pkg::SPAN_W-1:0]    b_b_reg,   b_b_next;
    // product stage
    logic                          m_v_reg,   m_v_next;
    cap_pkg::cap_cls_t             m_cls_reg, m_cls_next;
    logic [cap_pkg::NUM_W-1:0]     m_num_reg, m_num_next;
    // divider stages, entry zero holds the range check
    logic                          d_v_reg    [DS];
    logic                          d_v_next   [DS];
    cap_pkg::cap_cls_t             d_cls_reg  [DS];
    cap_pkg::cap_cls_t             d_cls_next [DS];
    logic                          d_over_reg [DS];
    logic                          d_over_next[DS];
    logic [cap_pkg::REM_W-1:0]     d_rem_reg  [DS];
    logic [cap_pkg::REM_W-1:0]     d_rem_next [DS];
    logic [F-1:0]                  d_q_reg    [DS];
    logic [F-1:0]                  d_q_next   [DS];

    logic [cap_pkg::REM_W-1:0]     sh [F];
    logic                          ge [F];

    logic signed [SW-1:0]          root_s, lo_s, hi_s, mx, mn, bd;

    always_comb begin
        root_s = $signed(SW'(in_root));
        lo_s   = $signed({in_part.lo_sel[cap_pkg::LO_W-1], in_part.lo_sel});
        hi_s   = $signed(SW'(in_part.hi_sel));
        mx     = (root_s > lo_s) ? root_s : lo_s;
        mn     = (hi_s < mx) ? hi_s : mx;
        bd     = mn - lo_s;

        b_v_next   = in_valid;
        b_cls_next = in_part.cls;
        b_a_next   = in_part.span;
        b_b_next   = bd[cap_pkg::SPAN_W-1:0];

        m_v_next   = b_v_reg;
        m_cls_next = b_cls_reg;
        m_num_next = cap_pkg::NUM_W'(b_a_reg) * cap_pkg::NUM_W'(b_b_reg);

        d_v_next[0]    = m_v_reg;
        d_cls_next[0]  = m_cls_reg;
        d_over_next[0] = m_num_reg >= den;
        d_rem_next[0]  = cap_pkg::REM_W'(m_num_reg);
        d_q_next[0]    = '0;
        for (int k = 1; k < DS; k++) begin
            sh[k-1]        = {d_rem_reg[k-1][cap_pkg::REM_W-2:0], 1'b0};
            ge[k-1]        = sh[k-1] >= cap_pkg::REM_W'(den);
            d_v_next[k]    = d_v_reg[k-1];
            d_cls_next[k]  = d_cls_reg[k-1];
            d_over_next[k] = d_over_reg[k-1];
            d_rem_next[k]  = ge[k-1] ? sh[k-1] - cap_pkg::REM_W'(den) : sh[k-1];
            d_q_next[k]    = {d_q_reg[k-1][F-2:0], ge[k-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            for (int k = 0; k < DS; k++) begin
                d_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            b_v_reg <= b_v_next;
            m_v_reg <= m_v_next;
            for (int k = 0; k < DS; k++) begin
                d_v_reg[k] <= d_v_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_cls_reg <= b_cls_next;
            b_a_reg   <= b_a_next;
            b_b_reg   <= b_b_next;
            m_cls_reg <= m_cls_next;
            m_num_reg <= m_num_next;
            for (int k = 0; k < DS; k++) begin
                d_cls_reg[k]  <= d_cls_next[k];
                d_over_reg[k] <= d_over_next[k];
                d_rem_reg[k]  <= d_rem_next[k];
                d_q_reg[k]    <= d_q_next[k];
            end
        end
    end

    always_comb begin
        case (d_cls_reg[DS-1])
            cap_pkg::CLS_FULL: out_cov = cap_pkg::UNIT_COV;
            cap_pkg::CLS_PART: out_cov = d_over_reg[DS-1] ? cap_pkg::UNIT_COV :
                                         {1'b0, d_q_reg[DS-1]};
            default:           out_cov = '0;
        endcase
    end

    assign out_valid = d_v_reg[DS-1];

endmodule

### rtl/core/circular_aperture_pixel_coverage_unit.sv
// throughput: one transaction per cycle while the skid entry is empty, every stage is pipelined
// the pipeline includes the 17 root-bit stages and the 17 divider stages
// a two-entry output buffer keeps s_tready high while one result waits
// reset: synchronous active-low aresetn clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
// circular_aperture_pixel_coverage_unit
// fraction of each grid pixel covered by a centered circular aperture
// ----------------------------------------------------------------------------
module circular_aperture_pixel_coverage_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // register write port
    input  logic                              cfg_wr_en,
    input  logic [cap_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [cap_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // pixel transactions
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cap_pkg::S_TDATA_W-1:0]     s_tdata,  // column [10:0], row [21:11]
    // coverage transactions
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cap_pkg::M_TDATA_W-1:0]     m_tdata   // coverage [16:0]
);

    `include "circular_aperture_pixel_coverage_unit_assert.svh"

    logic [cap_pkg::IDX_W-1:0]   side_reg, side_next;
    logic [cap_pkg::INV_W-1:0]   inv_reg,  inv_next;
    logic [cap_pkg::NUM_W-1:0]   den_reg,  den_next;
    logic [cap_pkg::IDX_W-1:0]   side_clip;
    logic [cap_pkg::SPAN_W-1:0]  two_h;
    cap_pkg::cap_cfg_t           cfg;

    logic                        m_valid_reg,    m_valid_next;
    logic [cap_pkg::COV_W-1:0]   m_cov_reg,      m_cov_next;
    logic                        skid_valid_reg, skid_valid_next;
    logic [cap_pkg::COV_W-1:0]   skid_cov_reg,   skid_cov_next;

    logic                        en;
    logic                        out_free;

    logic                        fe_valid;
    logic [cap_pkg::ARG_W-1:0]   fe_arg;
    cap_pkg::cap_part_t          fe_part;
    logic                        sq_valid;
    logic [cap_pkg::ROOT_W-1:0]  sq_root;
    cap_pkg::cap_part_t          sq_part;
    logic                        res_valid;
    logic [cap_pkg::COV_W-1:0]   res_cov;

    // register writes, radius in pixels has no effect on coverage
    always_comb begin
        side_next = side_reg;
        inv_next  = inv_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                cap_pkg::CFG_SIDE_LENGTH:    side_next = cfg_wr_data[cap_pkg::IDX_W-1:0];
                cap_pkg::CFG_INVERSE_RADIUS: inv_next  = cfg_wr_data[cap_pkg::INV_W-1:0];
                cap_pkg::CFG_RADIUS_PIXELS:  side_next = side_reg;
                default:                     side_next = side_reg;
            endcase
        end
    end

    always_comb begin
        side_clip  = (side_reg > cap_pkg::IDX_W'(cap_pkg::MAX_SIDE)) ?
                     cap_pkg::IDX_W'(cap_pkg::MAX_SIDE) : side_reg;
        cfg.center = cap_pkg::IDX_W'(1) + (side_clip >> 1);
        cfg.inv    = inv_reg;
        cfg.half   = inv_reg[cap_pkg::INV_W-1:1];
        two_h      = {inv_reg[cap_pkg::INV_W-1:1], 1'b0};
        den_next   = cap_pkg::NUM_W'(two_h) * cap_pkg::NUM_W'(two_h);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= cap_pkg::SIDE_RST;
            inv_reg  <= cap_pkg::INV_RST;
        end else begin
            side_reg <= side_next;
            inv_reg  <= inv_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign out_free = !m_valid_reg || m_tready;

    cap_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_col    (s_tdata[cap_pkg::IDX_W-1:0]),
        .in_row    (s_tdata[2*cap_pkg::IDX_W-1:cap_pkg::IDX_W]),
        .out_valid (fe_valid),
        .out_arg   (fe_arg),
        .out_part  (fe_part)
    );

    cap_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fe_valid),
        .in_arg    (fe_arg),
        .in_part   (fe_part),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_part  (sq_part)
    );

    cap_ratio u_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .den       (den_reg),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_part   (sq_part),
        .out_valid (res_valid),
        .out_cov   (res_cov)
    );

    // output register with one skid entry
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_cov_next      = m_cov_reg;
        skid_valid_next = skid_valid_reg;
        skid_cov_next   = skid_cov_reg;
        if (en) begin
            if (out_free) begin
                m_valid_next = res_valid;
                m_cov_next   = res_cov;
            end else if (res_valid) begin
                skid_valid_next = 1'b1;
                skid_cov_next   = res_cov;
            end
        end else if (m_tready) begin
            m_cov_next      = skid_cov_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_cov_reg    <= m_cov_next;
        skid_cov_reg <= skid_cov_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = cap_pkg::M_TDATA_W'(m_cov_reg);

    `CAP_ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg, "skid full with empty output")
    `CAP_ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg && $stable(skid_cov_reg), "skid entry lost")
    `CAP_ASSERT_NEXT(a_result_to_skid, aclk, aresetn, en && res_valid && !out_free, skid_valid_reg, "stalled result dropped")
    `CAP_ASSERT_HOLDS(a_cov_range, aclk, aresetn, !m_valid_reg || (m_cov_reg <= cap_pkg::UNIT_COV), "coverage above unit")

endmodule

### tb/circular_aperture_pixel_coverage_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular aperture pixel coverage checker
// watches the register port and both streams, keeps its own register copy,
// computes the coverage of every accepted pixel and compares it in order
// ----------------------------------------------------------------------------
module circular_aperture_pixel_coverage_checker
    import cap_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // column [10:0], row [21:11]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // coverage [16:0]
    output int                    mismatches,
    output int                    pending,
    output int                    checked,
    output int                    rim_hits
);

    localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(32768);
    localparam longint COORD_TOP = (longint'(1) << (FRAC_BITS + 4)) - 1;
    localparam longint UNIT_AREA = longint'(1) << (2 * FRAC_BITS);

    typedef struct {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [COV_W-1:0] cov;
    } pixel_result_t;

    pixel_result_t coverage_q[$];

    logic [IDX_W-1:0] side_reg;
    logic [INV_W-1:0] inv_reg;
    logic [RAD_W-1:0] rad_reg;

    int err_cnt   = 0;
    int check_cnt = 0;
    int rim_cnt   = 0;

    function automatic longint floor_root(input longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            t = r + (longint'(1) << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // normalized low and high edge of the pixel along one axis
    function automatic void axis_span(input longint idx, input longint center,
                                      input longint inv, input longint half,
                                      output longint lo, output longint hi);
        longint d;
        longint c;
        d = idx - center;
        if (d < 0) begin
            d = -d;
        end
        c  = d * inv;
        lo = c - half;
        hi = c + half;
        if (lo > COORD_TOP) begin
            lo = COORD_TOP;
        end
        if (hi > COORD_TOP) begin
            hi = COORD_TOP;
        end
    endfunction

    function automatic logic [COV_W-1:0] predict_coverage(input logic [IDX_W-1:0] col,
                                                          input logic [IDX_W-1:0] row,
                                                          output cap_cls_t cls);
        longint side, center, inv, half;
        longint xl, xh, yl, yh, xhs, yhs, rsl, rsh;
        longint sx, sy, a, b, num, den;
        side = longint'(side_reg);
        if (side > MAX_SIDE) begin
            side = MAX_SIDE;
        end
        center = 1 + side / 2;
        inv    = longint'(inv_reg);
        half   = inv >> 1;
        axis_span(longint'(col), center, inv, half, xl, xh);
        axis_span(longint'(row), center, inv, half, yl, yh);
        xhs = xh * xh;
        yhs = yh * yh;
        rsl = xl * xl + yl * yl;
        rsh = xhs + yhs;
        if (rsl > UNIT_AREA) begin
            cls = CLS_ZERO;
            return '0;
        end
        if (rsh < UNIT_AREA) begin
            cls = CLS_FULL;
            return UNIT_COV;
        end
        cls = CLS_PART;
        if (half == 0) begin
            return '0;
        end
        sx = floor_root((yhs < UNIT_AREA) ? UNIT_AREA - yhs : 0);
        sy = floor_root((xhs < UNIT_AREA) ? UNIT_AREA - xhs : 0);
        if (xh > yh) begin
            a = yh - yl;
            b = (xl > sx) ? xl : sx;
            if (b > xh) begin
                b = xh;
            end
            b = b - xl;
        end else begin
            a = xh - xl;
            b = (yl > sy) ? yl : sy;
            if (b > yh) begin
                b = yh;
            end
            b = b - yl;
        end
        if (a < 0) begin
            a = 0;
        end
        if (b < 0) begin
            b = 0;
        end
        num = a * b;
        den = 4 * half * half;
        if (num >= den) begin
            return UNIT_COV;
        end
        return COV_W'((num << FRAC_BITS) / den);
    endfunction

    always @(posedge aclk) begin : monitor
        pixel_result_t item;
        pixel_result_t want;
        cap_cls_t      cls;
        if (!aresetn) begin
            side_reg <= SIDE_RST;
            inv_reg  <= INV_RST;
            rad_reg  <= RAD_RESET;
            coverage_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_SIDE_LENGTH: begin
                        side_reg <= cfg_wr_data[IDX_W-1:0];
                    end
                    CFG_INVERSE_RADIUS: begin
                        inv_reg <= cfg_wr_data[INV_W-1:0];
                    end
                    CFG_RADIUS_PIXELS: begin
                        rad_reg <= cfg_wr_data[RAD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (coverage_q.size() == 0) begin
                    $display("%0t: coverage transaction %0d with nothing expected",
                             $time, m_tdata[COV_W-1:0]);
                    err_cnt++;
                end else begin
                    want = coverage_q.pop_front();
                    check_cnt++;
                    if (m_tdata[COV_W-1:0] !== want.cov) begin
                        $display("%0t: coverage of pixel (%0d, %0d): expected %0d, actual %0d",
                                 $time, want.col, want.row, want.cov, m_tdata[COV_W-1:0]);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item.col = s_tdata[IDX_W-1:0];
                item.row = s_tdata[2*IDX_W-1:IDX_W];
                item.cov = predict_coverage(item.col, item.row, cls);
                if (cls == CLS_PART) begin
                    rim_cnt++;
                end
                coverage_q.insert(coverage_q.size(), item);
            end
        end
        mismatches <= err_cnt;
        pending    <= coverage_q.size();
        checked    <= check_cnt;
        rim_hits   <= rim_cnt;
    end

endmodule

### tb/tb_circular_aperture_pixel_coverage_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_aperture_pixel_coverage_unit
// directed edge pixels, then raster-free random pixels clustered on the
// aperture rim under many register settings, with bursty input, receiver
// stalls and a long output hold-off; results are checked by the checker
// ----------------------------------------------------------------------------
module tb_circular_aperture_pixel_coverage_unit;
    import cap_pkg::*;

    localparam int ITEM_TOTAL  = 1950;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = (ITEM_TOTAL - 20) / PHASES;
    localparam int HOLD_PHASE  = 2;
    localparam int PAUSE_PHASE = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_TAIL  = 60;
    localparam int IDX_TOP     = (1 << IDX_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(3);

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_tvalid     = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata      = '0;
    logic                  m_tready     = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;

    int mismatches;
    int pending;
    int checked;
    int rim_hits;

    int       burst_left    = 0;
    int       sent          = 0;
    int       settings_used = 0;
    bit       tx_gaps       = 1'b0;
    rx_mode_t rx_mode       = RX_ALWAYS;
    int       hold_requests = 0;
    int       hold_served   = 0;
    int       hold_left     = 0;
    int       rx_tick       = 0;
    int       quiet         = 0;

    logic [IDX_W-1:0] cur_side = SIDE_RST;
    logic [INV_W-1:0] cur_inv  = INV_RST;

    initial begin
        forever #5 aclk = ~aclk;
    end

    circular_aperture_pixel_coverage_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    circular_aperture_pixel_coverage_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .rim_hits     (rim_hits)
    );

    // output backpressure
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_tready <= ($urandom_range(0, 99) < 70);
                end
                RX_PATTERN: begin
                    m_tready <= ((rx_tick % 9) < 5);
                end
                default: begin
                    m_tready <= ($urandom_range(0, 99) < 25);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = $urandom_range(1, 10);
            s_tvalid  <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({row, col});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic apply_config(input logic [IDX_W-1:0] side, input logic [INV_W-1:0] inv,
                                input logic [RAD_W-1:0] rad);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_SIDE_LENGTH;
        cfg_wr_data  <= {junk[CFG_DATA_W-1:IDX_W], side};
        @(posedge aclk);
        cfg_wr_index <= CFG_INVERSE_RADIUS;
        cfg_wr_data  <= {junk[CFG_DATA_W-1:INV_W], inv};
        @(posedge aclk);
        cfg_wr_index <= CFG_RADIUS_PIXELS;
        cfg_wr_data  <= rad;
        @(posedge aclk);
        // index past the register list must leave everything alone
        cfg_wr_index <= CFG_SPARE_INDEX;
        cfg_wr_data  <= junk;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_side   = side;
        cur_inv    = inv;
        settings_used++;
    endtask

    // mostly pixels straddling the rim, some inside the grid, some anywhere
    task automatic random_pixel(output logic [IDX_W-1:0] col, output logic [IDX_W-1:0] row);
        int  side, center, sel, dx, dy, t;
        real r, rest;
        side   = (cur_side > MAX_SIDE) ? MAX_SIDE : cur_side;
        center = 1 + side / 2;
        sel    = $urandom_range(0, 99);
        if (sel < 60 && cur_inv != 0) begin
            r = 65536.0 / real'(cur_inv);
            if (r > 2100.0) begin
                r = 2100.0;
            end
            dx   = $urandom_range(0, $rtoi(r) + 2);
            rest = r * r - real'(dx) * real'(dx);
            dy   = (rest > 0.0) ? $rtoi($sqrt(rest)) : 0;
            t    = $urandom_range(0, 4);
            dy   = dy + t - 2;
            if ($urandom_range(0, 1) == 1) begin
                dx = -dx;
            end
            if ($urandom_range(0, 1) == 1) begin
                dy = -dy;
            end
            if ($urandom_range(0, 1) == 1) begin
                t  = dx;
                dx = dy;
                dy = t;
            end
            dx  = center + dx;
            dy  = center + dy;
            col = (dx < 0) ? '0 : (dx > IDX_TOP) ? '1 : IDX_W'(dx);
            row = (dy < 0) ? '0 : (dy > IDX_TOP) ? '1 : IDX_W'(dy);
        end else if (sel < 85) begin
            t   = (cur_side == 0) ? 1 : cur_side;
            col = IDX_W'($urandom_range(1, t));
            row = IDX_W'($urandom_range(1, t));
        end else begin
            col = IDX_W'($urandom_range(0, IDX_TOP));
            row = IDX_W'($urandom_range(0, IDX_TOP));
        end
    endtask

    initial begin : stimulus
        logic [IDX_W-1:0] col, row;
        logic [IDX_W-1:0] p_side;
        logic [INV_W-1:0] p_inv;
        logic [RAD_W-1:0] p_rad;
        int               r_px, q;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: center 129, radius 128 pixels
        send_pixel(11'd129, 11'd129);
        send_pixel(11'd1, 11'd1);
        send_pixel(11'd256, 11'd256);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd0, 11'd2047);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd257, 11'd129);
        send_pixel(11'd256, 11'd129);
        send_pixel(11'd129, 11'd1);
        send_pixel(11'd1, 11'd129);
        send_pixel(11'd220, 11'd220);
        send_pixel(11'd221, 11'd219);
        send_pixel(11'd219, 11'd221);
        send_pixel(11'd38, 11'd38);
        send_pixel(11'd1365, 11'd682);
        drain();

        // oversized grid, radius below one pixel, coordinates saturating
        apply_config(11'd2047, 17'd131071, 19'd128);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd513, 11'd513);
        send_pixel(11'd514, 11'd513);
        send_pixel(11'd682, 11'd1365);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    p_side = 11'd256;
                    p_inv  = 17'd512;
                end
                1: begin
                    p_side = 11'd1024;
                    p_inv  = 17'd128;
                end
                2: begin
                    p_side = 11'd100;
                    p_inv  = 17'd1000;
                end
                3: begin
                    p_side = 11'd2047;
                    p_inv  = 17'd64;
                end
                4: begin
                    p_side = 11'd1;
                    p_inv  = 17'd65536;
                end
                5: begin
                    p_side = 11'd513;
                    p_inv  = 17'd131071;
                end
                6: begin
                    p_side = 11'd37;
                    p_inv  = 17'd3000;
                end
                7: begin
                    p_side = 11'd64;
                    p_inv  = 17'd1;
                end
                8: begin
                    p_side = 11'd0;
                    p_inv  = 17'd0;
                end
                9: begin
                    p_side = 11'd700;
                    p_inv  = 17'd200;
                end
                default: begin
                    p_side = IDX_W'($urandom_range(1, IDX_TOP));
                    r_px   = $urandom_range(1, 700);
                    p_inv  = INV_W'(65536 / r_px);
                end
            endcase
            q = (p_inv == 0) ? 524287 : 16777216 / int'(p_inv);
            if (q > 524287) begin
                q = 524287;
            end
            p_rad = RAD_W'(q);
            apply_config(p_side, p_inv, p_rad);
            rx_mode = rx_mode_t'(phase % 4);
            tx_gaps = (phase % 3 != 0) && (phase != HOLD_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == HOLD_PHASE && n == 30) begin
                    hold_requests++;
                end
                if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                random_pixel(col, row);
                send_pixel(col, row);
            end
            drain();
        end

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (pending != 0) begin
            $display("%0d coverage results never arrived", pending);
        end
        $display("run: %0d pixel transactions under %0d register settings, %0d results checked",
                 sent, settings_used + 1, checked);
        $display("run: %0d rim pixels, %0d long output hold-off with the input stalled",
                 rim_hits, hold_requests);
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
